>>> rtl/iea_pkg.sv
`timescale 1ns / 1ps

package iea_pkg;

	// Width of the address and data fields of one request.
	localparam int unsigned FIELD_W = 16;

	// Depth of the queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_TWO_BYTE_ADDR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT   = 2'd1;

	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	// Device bytes for the write and the read phase.
	localparam logic [7:0] DEV_WRITE = 8'hA0;
	localparam logic [7:0] DEV_READ  = 8'hA1;

	// Steps of one access.
	typedef enum logic [4:0] {
		ST_IDLE     = 5'd0,
		ST_START    = 5'd1,
		ST_DEV_TX   = 5'd2,
		ST_DEV_ACK  = 5'd3,
		ST_AHI_TX   = 5'd4,
		ST_AHI_ACK  = 5'd5,
		ST_ALO_TX   = 5'd6,
		ST_ALO_ACK  = 5'd7,
		ST_RESTART  = 5'd8,
		ST_DEVR_TX  = 5'd9,
		ST_DEVR_ACK = 5'd10,
		ST_WHI_TX   = 5'd11,
		ST_WHI_ACK  = 5'd12,
		ST_WLO_TX   = 5'd13,
		ST_WLO_ACK  = 5'd14,
		ST_RHI_RX   = 5'd15,
		ST_RHI_MACK = 5'd16,
		ST_RLO_RX   = 5'd17,
		ST_RLO_MACK = 5'd18,
		ST_STOP     = 5'd19
	} step_t;

	// One classified input item as it travels through the queue.
	typedef struct packed {
		logic               is_request;
		logic               is_write;
		logic               two_bytes;
		logic [FIELD_W-1:0] addr;
		logic [FIELD_W-1:0] data;
		logic               sda;
	} item_t;

	// Live configuration.
	typedef struct packed {
		logic       two_byte_addr;
		logic [7:0] ack_timeout;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic               scl;
		logic               sda_drive;
		logic               sda_enable;
		logic               busy;
		logic               done;
		logic [FIELD_W-1:0] read_value;
		logic               ack_error;
	} res_t;

endpackage

>>> rtl/iea_front.sv
`timescale 1ns / 1ps

module iea_front #(
	parameter int unsigned ADDRESS_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             kind,
	input  logic                             is_write,
	input  logic                             two_bytes,
	input  logic [ADDRESS_WIDTH-1:0]         mem_address,
	input  logic [iea_pkg::FIELD_W-1:0]      write_value,
	input  logic                             sda_sample,
	output logic                             push,
	output iea_pkg::item_t                   push_item,
	input  logic                             queue_ready
);

	logic           valid_s1;
	iea_pkg::item_t item_s1;
	logic           accept;

	// The input register stalls only while its item cannot enter the queue.
	assign req_stall = valid_s1 && !queue_ready;
	assign accept    = req_valid && !req_stall;
	assign push      = valid_s1 && queue_ready;
	assign push_item = item_s1;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify the item and confine the address to the field width.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.is_request <= kind;
			item_s1.is_write   <= is_write;
			item_s1.two_bytes  <= two_bytes;
			item_s1.addr       <= iea_pkg::FIELD_W'(mem_address);
			item_s1.data       <= write_value;
			item_s1.sda        <= sda_sample;
		end
	end

endmodule

>>> rtl/iea_queue.sv
`timescale 1ns / 1ps

module iea_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  iea_pkg::item_t push_item,
	output logic           ready,
	input  logic           pop,
	output logic           pop_valid,
	output iea_pkg::item_t pop_item
);

	iea_pkg::item_t                  entry_q [iea_pkg::QUEUE_DEPTH];
	logic [iea_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [iea_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [iea_pkg::QCNT_W-1:0]      count_q;

	assign ready     = count_q != iea_pkg::QCNT_W'(iea_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + iea_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + iea_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + iea_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - iea_pkg::QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// The queue never takes an item while full and never gives one while empty.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> ready)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> pop_valid)
		else $error("queue read while empty");

endmodule

>>> rtl/iea_back.sv
`timescale 1ns / 1ps

module iea_back (
	input  logic           clk,
	input  logic           arst_n,
	input  iea_pkg::cfg_t  cfg,
	input  logic           item_valid,
	input  iea_pkg::item_t item,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output iea_pkg::res_t  res
);

	// Sequencer state.
	iea_pkg::step_t             step_q, step_n;
	logic [1:0]                 phase_q, phase_n;
	logic [2:0]                 bit_q, bit_n;
	logic [7:0]                 shift_q, shift_n;
	logic [7:0]                 wait_q, wait_n;
	logic                       wr_q, wr_n;
	logic                       two_q, two_n;
	logic [iea_pkg::FIELD_W-1:0] addr_q, addr_n;
	logic [iea_pkg::FIELD_W-1:0] data_q, data_n;
	logic [iea_pkg::FIELD_W-1:0] acc_q, acc_n;
	logic                       err_q, err_n;

	logic           do_enter;
	iea_pkg::step_t enter_step;
	logic           start_now;
	iea_pkg::step_t eff_step;
	logic [1:0]     eff_phase;
	iea_pkg::res_t  res_d;
	logic           res_valid_q;
	iea_pkg::res_t  res_q;

	// Byte sent in a transmit step.
	function automatic logic [7:0] tx_byte(
		input iea_pkg::step_t              s,
		input logic                        two_byte_addr,
		input logic [iea_pkg::FIELD_W-1:0] a,
		input logic [iea_pkg::FIELD_W-1:0] d
	);
		logic [7:0] b;
		begin
			unique case (s)
				iea_pkg::ST_DEV_TX: begin
					b = two_byte_addr ? iea_pkg::DEV_WRITE
						: iea_pkg::DEV_WRITE + {a[14:8], 1'b0};
				end
				iea_pkg::ST_AHI_TX:  b = a[15:8];
				iea_pkg::ST_ALO_TX:  b = a[7:0];
				iea_pkg::ST_DEVR_TX: b = iea_pkg::DEV_READ;
				iea_pkg::ST_WHI_TX:  b = d[15:8];
				default:             b = d[7:0];
			endcase
			return b;
		end
	endfunction

	// Acknowledge step that follows a transmit step.
	function automatic iea_pkg::step_t tx_follow(input iea_pkg::step_t s);
		iea_pkg::step_t f;
		begin
			unique case (s)
				iea_pkg::ST_DEV_TX:  f = iea_pkg::ST_DEV_ACK;
				iea_pkg::ST_AHI_TX:  f = iea_pkg::ST_AHI_ACK;
				iea_pkg::ST_ALO_TX:  f = iea_pkg::ST_ALO_ACK;
				iea_pkg::ST_DEVR_TX: f = iea_pkg::ST_DEVR_ACK;
				iea_pkg::ST_WHI_TX:  f = iea_pkg::ST_WHI_ACK;
				default:             f = iea_pkg::ST_WLO_ACK;
			endcase
			return f;
		end
	endfunction

	// An item is taken whenever the output register is free or being emptied.
	assign pop       = item_valid && (!res_valid_q || !res_stall);
	assign start_now = pop && item.is_request && (step_q == iea_pkg::ST_IDLE);

	// Next-state logic: a request in idle latches, a tick advances one quarter.
	always_comb begin
		step_n     = step_q;
		phase_n    = phase_q;
		bit_n      = bit_q;
		shift_n    = shift_q;
		wait_n     = wait_q;
		wr_n       = wr_q;
		two_n      = two_q;
		addr_n     = addr_q;
		data_n     = data_q;
		acc_n      = acc_q;
		err_n      = err_q;
		do_enter   = 1'b0;
		enter_step = iea_pkg::ST_IDLE;
		if (start_now) begin
			wr_n    = item.is_write;
			two_n   = item.two_bytes;
			addr_n  = item.addr;
			data_n  = item.data;
			err_n   = 1'b0;
			acc_n   = '0;
			step_n  = iea_pkg::ST_START;
			phase_n = '0;
			bit_n   = '0;
			wait_n  = '0;
			shift_n = '0;
		end else if (pop && !item.is_request) begin
			unique case (step_q) inside
				iea_pkg::ST_START, iea_pkg::ST_RESTART: begin
					if (phase_q == 2'd3) begin
						do_enter   = 1'b1;
						enter_step = (step_q == iea_pkg::ST_START) ? iea_pkg::ST_DEV_TX
							: iea_pkg::ST_DEVR_TX;
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				iea_pkg::ST_DEV_TX, iea_pkg::ST_AHI_TX, iea_pkg::ST_ALO_TX,
				iea_pkg::ST_DEVR_TX, iea_pkg::ST_WHI_TX, iea_pkg::ST_WLO_TX: begin
					if (phase_q == 2'd3) begin
						shift_n = {shift_q[6:0], 1'b0};
						if (bit_q == 3'd7) begin
							do_enter   = 1'b1;
							enter_step = tx_follow(step_q);
						end else begin
							bit_n   = bit_q + 3'd1;
							phase_n = '0;
						end
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				iea_pkg::ST_DEV_ACK, iea_pkg::ST_AHI_ACK, iea_pkg::ST_ALO_ACK,
				iea_pkg::ST_DEVR_ACK, iea_pkg::ST_WHI_ACK, iea_pkg::ST_WLO_ACK: begin
					if (phase_q != 2'd3) begin
						phase_n = phase_q + 2'd1;
					end else if (!item.sda) begin
						do_enter = 1'b1;
						unique case (step_q)
							iea_pkg::ST_DEV_ACK: begin
								enter_step = cfg.two_byte_addr ? iea_pkg::ST_AHI_TX
									: iea_pkg::ST_ALO_TX;
							end
							iea_pkg::ST_AHI_ACK: enter_step = iea_pkg::ST_ALO_TX;
							iea_pkg::ST_ALO_ACK: begin
								if (wr_q) begin
									enter_step = two_q ? iea_pkg::ST_WHI_TX
										: iea_pkg::ST_WLO_TX;
								end else begin
									enter_step = iea_pkg::ST_RESTART;
								end
							end
							iea_pkg::ST_DEVR_ACK: begin
								enter_step = two_q ? iea_pkg::ST_RHI_RX
									: iea_pkg::ST_RLO_RX;
							end
							iea_pkg::ST_WHI_ACK: enter_step = iea_pkg::ST_WLO_TX;
							default:             enter_step = iea_pkg::ST_STOP;
						endcase
					end else if (wait_q >= cfg.ack_timeout) begin
						err_n      = 1'b1;
						do_enter   = 1'b1;
						enter_step = iea_pkg::ST_STOP;
					end else begin
						wait_n = wait_q + 8'd1;
					end
				end
				iea_pkg::ST_RHI_RX, iea_pkg::ST_RLO_RX: begin
					if (phase_q == 2'd2) begin
						shift_n = {shift_q[6:0], item.sda};
					end
					if (phase_q == 2'd3) begin
						if (bit_q == 3'd7) begin
							acc_n      = {acc_q[7:0], shift_q};
							do_enter   = 1'b1;
							enter_step = (step_q == iea_pkg::ST_RHI_RX) ? iea_pkg::ST_RHI_MACK
								: iea_pkg::ST_RLO_MACK;
						end else begin
							bit_n   = bit_q + 3'd1;
							phase_n = '0;
						end
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				iea_pkg::ST_RHI_MACK, iea_pkg::ST_RLO_MACK: begin
					if (phase_q == 2'd3) begin
						do_enter   = 1'b1;
						enter_step = (step_q == iea_pkg::ST_RHI_MACK) ? iea_pkg::ST_RLO_RX
							: iea_pkg::ST_STOP;
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				iea_pkg::ST_STOP: begin
					if (phase_q == 2'd3) begin
						step_n  = iea_pkg::ST_IDLE;
						phase_n = '0;
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				default: begin
					step_n  = iea_pkg::ST_IDLE;
					phase_n = '0;
				end
			endcase
		end
		// Entering a step clears its counters and, for a transmit step, loads the byte to send.
		if (do_enter) begin
			step_n  = enter_step;
			phase_n = '0;
			bit_n   = '0;
			wait_n  = '0;
			unique case (enter_step) inside
				iea_pkg::ST_DEV_TX, iea_pkg::ST_AHI_TX, iea_pkg::ST_ALO_TX,
				iea_pkg::ST_DEVR_TX, iea_pkg::ST_WHI_TX, iea_pkg::ST_WLO_TX: begin
					shift_n = tx_byte(enter_step, cfg.two_byte_addr, addr_q, data_q);
				end
				default: shift_n = '0;
			endcase
		end
	end

	// Output logic: pin levels of the step the item sees.
	always_comb begin
		eff_step  = start_now ? iea_pkg::ST_START : step_q;
		eff_phase = start_now ? 2'd0 : phase_q;
		res_d.scl        = 1'b1;
		res_d.sda_drive  = 1'b1;
		res_d.sda_enable = 1'b1;
		res_d.busy       = 1'b1;
		res_d.done       = 1'b0;
		unique case (eff_step) inside
			iea_pkg::ST_START: begin
				res_d.scl       = eff_phase != 2'd3;
				res_d.sda_drive = eff_phase == 2'd0;
			end
			iea_pkg::ST_RESTART: begin
				res_d.scl       = (eff_phase == 2'd1) || (eff_phase == 2'd2);
				res_d.sda_drive = !eff_phase[1];
			end
			iea_pkg::ST_DEV_TX, iea_pkg::ST_AHI_TX, iea_pkg::ST_ALO_TX,
			iea_pkg::ST_DEVR_TX, iea_pkg::ST_WHI_TX, iea_pkg::ST_WLO_TX: begin
				res_d.scl       = eff_phase[1];
				res_d.sda_drive = shift_q[7];
			end
			iea_pkg::ST_DEV_ACK, iea_pkg::ST_AHI_ACK, iea_pkg::ST_ALO_ACK,
			iea_pkg::ST_DEVR_ACK, iea_pkg::ST_WHI_ACK, iea_pkg::ST_WLO_ACK,
			iea_pkg::ST_RHI_RX, iea_pkg::ST_RLO_RX: begin
				res_d.scl        = eff_phase[1];
				res_d.sda_enable = 1'b0;
			end
			iea_pkg::ST_RHI_MACK, iea_pkg::ST_RLO_MACK: begin
				res_d.scl       = eff_phase[1];
				res_d.sda_drive = eff_step != iea_pkg::ST_RHI_MACK;
			end
			iea_pkg::ST_STOP: begin
				res_d.scl       = eff_phase != 2'd0;
				res_d.sda_drive = eff_phase[1];
				res_d.done      = eff_phase == 2'd3;
			end
			default: res_d.busy = 1'b0;
		endcase
		res_d.read_value = (res_d.done && !wr_q) ? acc_q : '0;
		res_d.ack_error  = res_d.done && err_q;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= iea_pkg::ST_IDLE;
			phase_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			wait_q  <= '0;
			wr_q    <= 1'b0;
			two_q   <= 1'b0;
			addr_q  <= '0;
			data_q  <= '0;
			acc_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			step_q  <= step_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			wait_q  <= wait_n;
			wr_q    <= wr_n;
			two_q   <= two_n;
			addr_q  <= addr_n;
			data_q  <= data_n;
			acc_q   <= acc_n;
			err_q   <= err_n;
		end
	end

	// Output register: holds a result until the next stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A request taken in idle always begins with the start condition.
	assert property (@(posedge clk) disable iff (!arst_n)
		start_now |=> (step_q == iea_pkg::ST_START) && (phase_q == 2'd0))
		else $error("request did not begin a start condition");

	// The last tick of the stop condition returns the sequencer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !item.is_request && (step_q == iea_pkg::ST_STOP) && (phase_q == 2'd3)
		|=> step_q == iea_pkg::ST_IDLE)
		else $error("stop condition did not end in idle");

	// A finished transaction is reported while still marked busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done |-> res_q.busy)
		else $error("done reported without busy");

	// The error flag and read data appear only with done.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.done |-> !res_q.ack_error && (res_q.read_value == '0))
		else $error("error or read data outside a done result");

endmodule

>>> rtl/i2c_eeprom_access_sequencer.sv
`timescale 1ns / 1ps
// Path: an accepted item passes the input register, then the queue, then the
// output register. Throughput: one item per cycle while neither stall holds;
// the sequencer takes one quarter-bit step per tick.
// Reset: arst_n clears the sequencer to idle, empties the queue and the output,
// and sets two_byte_addr to 0 and ack_timeout to 250.
module i2c_eeprom_access_sequencer #(
	parameter int unsigned ADDRESS_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               kind,
	input  logic                               is_write,
	input  logic                               two_bytes,
	input  logic [ADDRESS_WIDTH-1:0]           mem_address,
	input  logic [iea_pkg::FIELD_W-1:0]        write_value,
	input  logic                               sda_sample,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic                               scl_level,
	output logic                               sda_drive,
	output logic                               sda_enable,
	output logic                               busy_res,
	output logic                               done_res,
	output logic [iea_pkg::FIELD_W-1:0]        read_value,
	output logic                               ack_error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [iea_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [iea_pkg::CFG_DATA_W-1:0]     cfg_data
);

	iea_pkg::cfg_t  cfg_q;
	logic           push;
	iea_pkg::item_t push_item;
	logic           queue_ready;
	logic           pop;
	logic           pop_valid;
	iea_pkg::item_t pop_item;
	iea_pkg::res_t  res;

	// Configuration registers; every write transaction is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_byte_addr <= 1'b0;
			cfg_q.ack_timeout   <= iea_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				iea_pkg::REG_TWO_BYTE_ADDR: cfg_q.two_byte_addr <= cfg_data[0];
				iea_pkg::REG_ACK_TIMEOUT:   cfg_q.ack_timeout   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	iea_front #(
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.is_write   (is_write),
		.two_bytes  (two_bytes),
		.mem_address(mem_address),
		.write_value(write_value),
		.sda_sample (sda_sample),
		.push       (push),
		.push_item  (push_item),
		.queue_ready(queue_ready)
	);

	iea_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.ready    (queue_ready),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_item (pop_item)
	);

	iea_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(pop_valid),
		.item      (pop_item),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Result fields onto their ports.
	assign scl_level  = res.scl;
	assign sda_drive  = res.sda_drive;
	assign sda_enable = res.sda_enable;
	assign busy_res   = res.busy;
	assign done_res   = res.done;
	assign read_value = res.read_value;
	assign ack_error  = res.ack_error;

endmodule
